>>> rtl/isq_pkg.sv
// isq_pkg: shared constants, codes and types of the indexed sequence store
// depends on nothing; used by the interfaces, the sequencer and the top level

package isq_pkg;

  localparam int unsigned CAPACITY   = 16;
  localparam int unsigned DATA_WIDTH = 32;

  localparam int unsigned ADDR_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);

  // item field widths
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned DIN_W    = 32;
  localparam int unsigned DOUT_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ICNT_W   = 5;

  // signed compare width for position against count
  localparam int unsigned CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [MODE_W-1:0] {
    ISQ_ADD_TAIL = 3'd0,
    ISQ_ADD_HEAD = 3'd1,
    ISQ_INSERT   = 3'd2,
    ISQ_RM_HEAD  = 3'd3,
    ISQ_RM_TAIL  = 3'd4,
    ISQ_RM_AT    = 3'd5,
    ISQ_READ_AT  = 3'd6
  } isq_mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ISQ_OK     = 2'd0,
    ISQ_BADPOS = 2'd1,
    ISQ_EMPTY  = 2'd2,
    ISQ_FULL   = 2'd3
  } isq_status_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PUT,
    OP_TAKE,
    OP_READ
  } isq_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CAP,
    ST_SHIFT_UP,
    ST_SHIFT_DN,
    ST_RESP
  } isq_state_e;

  typedef struct packed {
    logic                  re;
    logic [ADDR_W-1:0]     raddr;
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [DATA_WIDTH-1:0] wdata;
  } isq_mem_req_t;

  typedef struct packed {
    logic [DOUT_W-1:0]   data_out;
    isq_status_e         status;
    logic [ICNT_W-1:0]   item_count;
    logic                is_empty;
  } isq_rsp_t;

  // logical position to ring address, head plus offset with one wrap
  function automatic logic [ADDR_W-1:0] isq_phys(input logic [ADDR_W-1:0] head,
                                                 input logic [CNT_W-1:0]  lpos);
    logic [ADDR_W:0] sum;
    sum = {1'b0, head} + {1'b0, lpos[ADDR_W-1:0]};
    if (sum >= (ADDR_W + 1)'(CAPACITY)) begin
      sum = sum - (ADDR_W + 1)'(CAPACITY);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

>>> rtl/isq_if.sv
// isq_if: request and result channel interfaces of the indexed sequence store
// depends on isq_pkg for the field widths

interface isq_req_if;
  import isq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [MODE_W-1:0]       mode;
  logic signed [POS_W-1:0] position;
  logic [DIN_W-1:0]        data_in;

  modport source (output valid, output mode, output position, output data_in,
                  input ready);
  modport sink   (input valid, input mode, input position, input data_in,
                  output ready);
endinterface

interface isq_rsp_if;
  import isq_pkg::*;

  logic                valid;
  logic                ready;
  logic [DOUT_W-1:0]   data_out;
  logic [STATUS_W-1:0] status;
  logic [ICNT_W-1:0]   item_count;
  logic                is_empty;

  modport source (output valid, output data_out, output status, output item_count,
                  output is_empty, input ready);
  modport sink   (input valid, input data_out, input status, input item_count,
                  input is_empty, output ready);
endinterface

>>> rtl/isq_ram.sv
// isq_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing

module isq_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> rtl/isq_ctrl.sv
// isq_ctrl: request decode and shift sequencer over the ring-addressed word ram
// depends on isq_pkg and isq_if; drives the ram through an isq_mem_req_t

module isq_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  isq_req_if.sink                   req_i,
  output logic                      rsp_valid_o,
  input  logic                      rsp_ready_i,
  output isq_pkg::isq_rsp_t         rsp_o,
  output isq_pkg::isq_mem_req_t     mem_o,
  input  logic [isq_pkg::DATA_WIDTH-1:0] mem_rdata_i
);
  import isq_pkg::*;

  isq_state_e            state_q, state_d;
  logic [ADDR_W-1:0]     head_q, head_d;
  logic [CNT_W-1:0]      count_q, count_d;
  isq_op_e               op_q, op_d;
  isq_status_e           status_q, status_d;
  logic [CNT_W-1:0]      lidx_q, lidx_d;
  logic [CNT_W-1:0]      cur_q, cur_d;
  logic                  pend_q, pend_d;
  logic [CNT_W-1:0]      pend_dst_q, pend_dst_d;
  logic [DATA_WIDTH-1:0] data_q, data_d;

  // decode of the incoming item
  isq_op_e               dec_op;
  isq_status_e           dec_status;
  logic [CNT_W-1:0]      dec_lidx;
  logic signed [CMP_W-1:0] pos_x, cnt_x, rd_idx;
  logic                  full, empty;
  logic [ADDR_W-1:0]     head_dec, head_inc;

  assign full     = (count_q >= CNT_W'(CAPACITY));
  assign empty    = (count_q == '0);
  assign pos_x    = CMP_W'(req_i.position);
  assign cnt_x    = $signed(CMP_W'(count_q));
  assign rd_idx   = req_i.position[POS_W-1] ? (cnt_x + pos_x) : pos_x;
  assign head_dec = (head_q == '0) ? ADDR_W'(CAPACITY - 1) : head_q - 1'b1;
  assign head_inc = (head_q == ADDR_W'(CAPACITY - 1)) ? '0 : head_q + 1'b1;

  always_comb begin
    dec_op     = OP_NONE;
    dec_status = ISQ_OK;
    dec_lidx   = '0;
    case (isq_mode_e'(req_i.mode))
      ISQ_ADD_TAIL, ISQ_ADD_HEAD: begin
        if (full) begin
          dec_status = ISQ_FULL;
        end else begin
          dec_op   = OP_PUT;
          dec_lidx = (isq_mode_e'(req_i.mode) == ISQ_ADD_TAIL) ? count_q : '0;
        end
      end
      ISQ_INSERT: begin
        if (pos_x < 0 || pos_x > cnt_x) begin
          dec_status = ISQ_BADPOS;
        end else if (full) begin
          dec_status = ISQ_FULL;
        end else begin
          dec_op   = OP_PUT;
          dec_lidx = CNT_W'(pos_x);
        end
      end
      ISQ_RM_HEAD, ISQ_RM_TAIL: begin
        if (empty) begin
          dec_status = ISQ_EMPTY;
        end else begin
          dec_op   = OP_TAKE;
          dec_lidx = (isq_mode_e'(req_i.mode) == ISQ_RM_HEAD) ? '0 : count_q - 1'b1;
        end
      end
      ISQ_RM_AT: begin
        if (pos_x < 0) begin
          dec_status = ISQ_BADPOS;
        end else if (pos_x == 0 && empty) begin
          dec_status = ISQ_EMPTY;
        end else if (pos_x >= cnt_x) begin
          dec_status = ISQ_BADPOS;
        end else begin
          dec_op   = OP_TAKE;
          dec_lidx = CNT_W'(pos_x);
        end
      end
      ISQ_READ_AT: begin
        if (rd_idx < 0 || rd_idx >= cnt_x) begin
          dec_status = ISQ_BADPOS;
        end else begin
          dec_op   = OP_READ;
          dec_lidx = CNT_W'(rd_idx);
        end
      end
      default: begin
        dec_op = OP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    status_q   <= status_d;
    lidx_q     <= lidx_d;
    cur_q      <= cur_d;
    pend_dst_q <= pend_dst_d;
    data_q     <= data_d;
  end

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    op_d        = op_q;
    status_d    = status_q;
    lidx_d      = lidx_q;
    cur_d       = cur_q;
    pend_d      = pend_q;
    pend_dst_d  = pend_dst_q;
    data_d      = data_q;
    req_i.ready = 1'b0;
    rsp_valid_o = 1'b0;
    mem_o       = '0;

    case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          op_d     = dec_op;
          status_d = dec_status;
          lidx_d   = dec_lidx;
          data_d   = DATA_WIDTH'(req_i.data_in);
          state_d  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (op_q)
          OP_PUT: begin
            if (lidx_q == '0) begin
              // front insert just moves the head back
              head_d      = head_dec;
              mem_o.we    = 1'b1;
              mem_o.waddr = head_dec;
              mem_o.wdata = data_q;
              count_d     = count_q + 1'b1;
              state_d     = ST_RESP;
            end else begin
              cur_d   = count_q;
              pend_d  = 1'b0;
              state_d = ST_SHIFT_UP;
            end
          end
          OP_TAKE, OP_READ: begin
            mem_o.re    = 1'b1;
            mem_o.raddr = isq_phys(head_q, lidx_q);
            state_d     = ST_CAP;
          end
          default: begin
            state_d = ST_RESP;
          end
        endcase
      end
      ST_CAP: begin
        data_d = mem_rdata_i;
        if (op_q == OP_READ) begin
          state_d = ST_RESP;
        end else if (lidx_q == '0) begin
          head_d  = head_inc;
          count_d = count_q - 1'b1;
          state_d = ST_RESP;
        end else begin
          cur_d   = lidx_q + 1'b1;
          pend_d  = 1'b0;
          state_d = ST_SHIFT_DN;
        end
      end
      ST_SHIFT_UP: begin
        // read one entry below, write it one place up on the next cycle
        if (pend_q) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = isq_phys(head_q, pend_dst_q);
          mem_o.wdata = mem_rdata_i;
        end
        if (cur_q > lidx_q) begin
          mem_o.re    = 1'b1;
          mem_o.raddr = isq_phys(head_q, cur_q - 1'b1);
          pend_d      = 1'b1;
          pend_dst_d  = cur_q;
          cur_d       = cur_q - 1'b1;
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          mem_o.we    = 1'b1;
          mem_o.waddr = isq_phys(head_q, lidx_q);
          mem_o.wdata = data_q;
          count_d     = count_q + 1'b1;
          state_d     = ST_RESP;
        end
      end
      ST_SHIFT_DN: begin
        if (pend_q) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = isq_phys(head_q, pend_dst_q);
          mem_o.wdata = mem_rdata_i;
        end
        if (cur_q < count_q) begin
          mem_o.re    = 1'b1;
          mem_o.raddr = isq_phys(head_q, cur_q);
          pend_d      = 1'b1;
          pend_dst_d  = cur_q - 1'b1;
          cur_d       = cur_q + 1'b1;
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          count_d = count_q - 1'b1;
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_o.data_out   = (op_q == OP_TAKE || op_q == OP_READ) ? DOUT_W'(data_q) : '0;
    rsp_o.status     = status_q;
    rsp_o.item_count = ICNT_W'(count_q);
    rsp_o.is_empty   = (count_q == '0);
  end

endmodule

>>> rtl/indexed_sequence_store_top.sv
// Indexed sequence store: ordered store of up to CAPACITY words kept in a ring
// addressed ram. Requests enter on req_i (mode, position, data_in); each gives
// exactly one item on rsp_o (data_out, status, item_count, is_empty).
// An item is taken when valid and ready are both high on a rising edge.
// Time from request accept to result valid depends on the mode and, for an
// insert or a remove at a position, on how many words must move.
// Word moves go one per cycle through the single ram write port; the next
// request is taken once the current one has its result staged.
// The result sits in an output register, so the sequencer can take a new
// request while the previous result waits; a stalled receiver holds the
// result and, once a second result is ready, holds the sequencer as well.
// Reset clears the count, the head pointer and the output valid; the ram
// contents are not cleared and unused entries are never read.
// Depends on isq_pkg, isq_if, isq_ram and isq_ctrl.

module indexed_sequence_store_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  isq_req_if.sink    req_i,
  isq_rsp_if.source  rsp_o
);
  import isq_pkg::*;

  isq_mem_req_t          mem_req;
  logic [DATA_WIDTH-1:0] mem_rdata;
  logic                  ctrl_rsp_valid;
  logic                  ctrl_rsp_ready;
  isq_rsp_t              ctrl_rsp;

  logic                  out_valid_q, out_valid_d;
  isq_rsp_t              out_q;

  isq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_valid_o (ctrl_rsp_valid),
    .rsp_ready_i (ctrl_rsp_ready),
    .rsp_o       (ctrl_rsp),
    .mem_o       (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  isq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH),
    .AW    (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  // output stage is free when empty or being drained this cycle
  assign ctrl_rsp_ready = !out_valid_q || rsp_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_rsp_valid && ctrl_rsp_ready) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_rsp_valid && ctrl_rsp_ready) begin
      out_q <= ctrl_rsp;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.data_out   = out_q.data_out;
  assign rsp_o.status     = out_q.status;
  assign rsp_o.item_count = out_q.item_count;
  assign rsp_o.is_empty   = out_q.is_empty;

endmodule
